@@ sv/ldm_pkg.sv @@
`timescale 1ns / 1ps

package ldm_pkg;

    // Default table geometry.
    localparam int NODES_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Operation codes carried on s_tuser.
    typedef enum logic [2:0] {
        FN_INS_HEAD = 3'd0,
        FN_INS_TAIL = 3'd1,
        FN_RM_HEAD  = 3'd2,
        FN_RM_TAIL  = 3'd3,
        FN_UNLINK   = 3'd4
    } func_t;

    // Result status carried on m_tuser.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_BAD   = 2'd3
    } status_t;

    // Operation sequencer.
    typedef enum logic [0:0] {
        SEQ_IDLE = 1'b0,
        SEQ_EXEC = 1'b1
    } seq_state_t;

endpackage

@@ sv/linked_deque_manager.sv @@
`timescale 1ns / 1ps

// Channel  | Dir | Fields (lowest bit first)                     | Beat
// ---------+-----+-----------------------------------------------+-----------------
// s_*      | in  | tdata: item_value, node_handle; tuser: func   | one operation
// m_*      | out | tdata: out_value, out_handle, count;          | one result
//          |     | tuser: status                                 |
//
// Each beat has an accept cycle and an execute cycle: the accept cycle reads the touched
// node entry from the value and link memories (synchronous read), and the execute cycle
// rewrites the links and loads the result register. A new beat is accepted while the
// previous result still waits; the execute cycle stalls only while that result is not taken.
// Reset (aresetn low, synchronous) empties the deque and marks every node free; the node
// tables need no clearing because a node entry is used only once an insert has written it.

module linked_deque_manager #(
    parameter int NODES       = ldm_pkg::NODES_DEF,
    parameter int VALUE_WIDTH = ldm_pkg::VALUE_WIDTH_DEF,
    localparam int HW   = $clog2(NODES),
    localparam int CW   = $clog2(NODES + 1),
    localparam int S_DW = ((VALUE_WIDTH + HW + 7) / 8) * 8,
    localparam int M_DW = ((VALUE_WIDTH + HW + CW + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,

    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [S_DW-1:0] s_tdata,   // item_value, node_handle, zero pad
    input  logic [2:0]      s_tuser,   // func

    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [M_DW-1:0] m_tdata,   // out_value, out_handle, count, zero pad
    output logic [1:0]      m_tuser    // status
);

    import ldm_pkg::*;

    // Node tables: one entry per node, read and written by the sequencer.
    logic [VALUE_WIDTH-1:0] value_mem [NODES];
    logic [HW-1:0]          next_mem  [NODES];
    logic [HW-1:0]          prev_mem  [NODES];

    logic [VALUE_WIDTH-1:0] rd_value_reg;
    logic [HW-1:0]          rd_next_reg;
    logic [HW-1:0]          rd_prev_reg;
    logic                   rd_en;
    logic [HW-1:0]          rd_addr;

    logic                   val_we;
    logic [HW-1:0]          val_wa;
    logic [VALUE_WIDTH-1:0] val_wd;
    logic                   nxt_we;
    logic [HW-1:0]          nxt_wa;
    logic [HW-1:0]          nxt_wd;
    logic                   prv_we;
    logic [HW-1:0]          prv_wa;
    logic [HW-1:0]          prv_wd;

    // Control state.
    seq_state_t       state_reg, state_next;
    logic [HW-1:0]    head_reg, head_next;
    logic [HW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic [NODES-1:0] free_map_reg, free_map_next;
    logic             m_valid_reg, m_valid_next;

    // Operation captured at accept.
    logic [2:0]             op_reg;
    logic [VALUE_WIDTH-1:0] in_value_reg;
    logic [HW-1:0]          in_handle_reg;

    // Result register.
    logic [VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    logic [HW-1:0]          out_handle_reg, out_handle_next;
    logic [1:0]             status_reg, status_next;
    logic [CW-1:0]          count_reg, count_next;

    logic                   accept;
    logic [VALUE_WIDTH-1:0] s_item_value;
    logic [HW-1:0]          s_node_handle;

    // Lowest free node: isolate the lowest set bit, then encode it.
    logic [NODES-1:0] free_onehot;
    logic [HW-1:0]    free_idx;

    // Execute-cycle helpers.
    logic rm_req;
    logic rm_head;
    logic in_range;

    assign s_item_value  = s_tdata[VALUE_WIDTH-1:0];
    assign s_node_handle = s_tdata[VALUE_WIDTH+HW-1:VALUE_WIDTH];

    assign s_tready = (state_reg == SEQ_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DW'({count_reg, out_handle_reg, out_value_reg});
    assign m_tuser  = status_reg;

    assign free_onehot = free_map_reg & (~free_map_reg + NODES'(1));

    always_comb begin
        for (int b = 0; b < HW; b++) begin
            free_idx[b] = 1'b0;
            for (int i = 0; i < NODES; i++) begin
                if (i[b]) begin
                    free_idx[b] = free_idx[b] | free_onehot[i];
                end
            end
        end
    end

    assign in_range = (CW'(in_handle_reg) < CW'(NODES));

    // Read address: the end node for an end removal, else the given handle.
    // An unlink of the head or tail node reads the same entry as the end
    // removal it turns into.
    always_comb begin
        unique case (s_tuser)
            FN_RM_HEAD: rd_addr = head_reg;
            FN_RM_TAIL: rd_addr = tail_reg;
            default:    rd_addr = s_node_handle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            value_mem[val_wa] <= val_wd;
        end
        if (nxt_we) begin
            next_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we) begin
            prev_mem[prv_wa] <= prv_wd;
        end
        if (rd_en) begin
            rd_value_reg <= value_mem[rd_addr];
            rd_next_reg  <= next_mem[rd_addr];
            rd_prev_reg  <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg        <= s_tuser;
            in_value_reg  <= s_item_value;
            in_handle_reg <= s_node_handle;
        end
        out_value_reg  <= out_value_next;
        out_handle_reg <= out_handle_next;
        status_reg     <= status_next;
        count_reg      <= count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= SEQ_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            free_map_reg <= '1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            occ_reg      <= occ_next;
            free_map_reg <= free_map_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // The self-links at the ends of the list are never read (the head's
    // prev link and the tail's next link), so each operation writes at most
    // one entry of each link table.
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        free_map_next   = free_map_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_handle_next = out_handle_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        rd_en           = 1'b0;
        val_we          = 1'b0;
        val_wa          = free_idx;
        val_wd          = in_value_reg;
        nxt_we          = 1'b0;
        nxt_wa          = free_idx;
        nxt_wd          = head_reg;
        prv_we          = 1'b0;
        prv_wa          = head_reg;
        prv_wd          = free_idx;
        rm_req          = 1'b0;
        rm_head         = 1'b0;

        unique case (state_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    rd_en      = 1'b1;
                    state_next = SEQ_EXEC;
                end
            end
            SEQ_EXEC: begin
                if (!m_valid_reg || m_tready) begin
                    state_next      = SEQ_IDLE;
                    m_valid_next    = 1'b1;
                    out_value_next  = '0;
                    out_handle_next = '0;
                    status_next     = STAT_BAD;

                    unique case (op_reg)
                        FN_INS_HEAD, FN_INS_TAIL: begin
                            if (occ_reg == CW'(NODES)) begin
                                status_next = STAT_FULL;
                            end else begin
                                status_next             = STAT_OK;
                                out_handle_next         = free_idx;
                                val_we                  = 1'b1;
                                free_map_next[free_idx] = 1'b0;
                                occ_next                = occ_reg + CW'(1);
                                if (occ_reg == '0) begin
                                    head_next = free_idx;
                                    tail_next = free_idx;
                                end else if (op_reg == FN_INS_HEAD) begin
                                    nxt_we    = 1'b1;
                                    nxt_wa    = free_idx;
                                    nxt_wd    = head_reg;
                                    prv_we    = 1'b1;
                                    prv_wa    = head_reg;
                                    prv_wd    = free_idx;
                                    head_next = free_idx;
                                end else begin
                                    prv_we    = 1'b1;
                                    prv_wa    = free_idx;
                                    prv_wd    = tail_reg;
                                    nxt_we    = 1'b1;
                                    nxt_wa    = tail_reg;
                                    nxt_wd    = free_idx;
                                    tail_next = free_idx;
                                end
                            end
                        end
                        FN_RM_HEAD: begin
                            rm_req  = 1'b1;
                            rm_head = 1'b1;
                        end
                        FN_RM_TAIL: begin
                            rm_req  = 1'b1;
                            rm_head = 1'b0;
                        end
                        FN_UNLINK: begin
                            if (!in_range || occ_reg == '0 || free_map_reg[in_handle_reg]) begin
                                status_next = STAT_BAD;
                            end else if (in_handle_reg == head_reg) begin
                                rm_req  = 1'b1;
                                rm_head = 1'b1;
                            end else if (in_handle_reg == tail_reg) begin
                                rm_req  = 1'b1;
                                rm_head = 1'b0;
                            end else begin
                                // Middle node: bridge its neighbors.
                                status_next                  = STAT_OK;
                                out_value_next               = rd_value_reg;
                                out_handle_next              = in_handle_reg;
                                free_map_next[in_handle_reg] = 1'b1;
                                occ_next                     = occ_reg - CW'(1);
                                nxt_we                       = 1'b1;
                                nxt_wa                       = rd_prev_reg;
                                nxt_wd                       = rd_next_reg;
                                prv_we                       = 1'b1;
                                prv_wa                       = rd_next_reg;
                                prv_wd                       = rd_prev_reg;
                            end
                        end
                        default: begin
                            status_next = STAT_BAD;
                        end
                    endcase

                    if (rm_req) begin
                        if (occ_reg == '0) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            status_next     = STAT_OK;
                            out_value_next  = rd_value_reg;
                            out_handle_next = rm_head ? head_reg : tail_reg;
                            occ_next        = occ_reg - CW'(1);
                            free_map_next[rm_head ? head_reg : tail_reg] = 1'b1;
                            if (occ_reg == CW'(1)) begin
                                head_next = '0;
                                tail_next = '0;
                            end else if (rm_head) begin
                                head_next = rd_next_reg;
                            end else begin
                                tail_next = rd_prev_reg;
                            end
                        end
                    end

                    count_next = occ_next;
                end
            end
        endcase
    end

endmodule

@@ test/tb_linked_deque_manager.sv @@
`timescale 1ns / 1ps

module tb_linked_deque_manager;

    import ldm_pkg::*;

    // Geometry of the default build, with the same packing rules as the block.
    localparam int NODES = NODES_DEF;
    localparam int VW    = VALUE_WIDTH_DEF;
    localparam int HW    = $clog2(NODES);
    localparam int CW    = $clog2(NODES + 1);
    localparam int S_DW  = ((VW + HW + 7) / 8) * 8;
    localparam int M_DW  = ((VW + HW + CW + 7) / 8) * 8;

    // Operation codes beyond the defined set; the block must flag them as bad.
    localparam logic [2:0] FN_UNUSED_LO  = 3'd5;
    localparam logic [2:0] FN_UNUSED_MID = 3'd6;
    localparam logic [2:0] FN_UNUSED_HI  = 3'd7;

    localparam int RANDOM_OPS     = 850;
    localparam int PHASE_LEN      = 107;
    localparam int MAX_GAP        = 10;
    localparam int PRESSURE_AT    = 400;
    localparam int PRESSURE_HOLD  = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    // One operation beat as the sender sees it. When pick_live is set, the
    // handle is replaced at issue time by a node that is currently in use, so
    // that unlinks mostly hit real nodes instead of bouncing off as bad.
    typedef struct {
        logic [2:0]    fn;
        logic [VW-1:0] value;
        logic [HW-1:0] handle;
        bit            pick_live;
        int unsigned   gap;
    } deque_cmd_t;

    typedef struct {
        logic [VW-1:0] value;
        logic [HW-1:0] handle;
        status_t       status;
        logic [CW-1:0] count;
    } deque_result_t;

    logic            aclk;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [S_DW-1:0] s_tdata  = '0;   // item_value, node_handle, zero pad
    logic [2:0]      s_tuser  = '0;   // func
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [M_DW-1:0] m_tdata;         // out_value, out_handle, count, zero pad
    logic [1:0]      m_tuser;         // status

    linked_deque_manager uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow deque. It mirrors the node table, the link arrays, the free
    // map and the end pointers, and is advanced once per accepted beat.
    // ------------------------------------------------------------------
    logic [VW-1:0]    node_value [NODES];
    logic [HW-1:0]    fwd_link   [NODES];
    logic [HW-1:0]    back_link  [NODES];
    logic [NODES-1:0] node_free = '1;
    logic [HW-1:0]    head_node = '0;
    logic [HW-1:0]    tail_node = '0;
    logic [CW-1:0]    live_count = '0;

    deque_cmd_t    pending_ops [$];
    deque_result_t awaited_results [$];
    deque_cmd_t    issued_op;

    int ops_total    = 0;
    int ops_accepted = 0;
    int results_seen = 0;
    int error_count  = 0;
    int send_wait    = 0;
    int recv_hold    = 0;
    int idle_cycles  = 0;

    // Pops the head or the tail. A single remaining node resets both ends to
    // zero; otherwise the new end node points back at itself.
    function automatic deque_result_t take_end(input bit from_head);
        deque_result_t r;
        logic [HW-1:0] n;
        r.value  = '0;
        r.handle = '0;
        r.status = STAT_EMPTY;
        r.count  = live_count;
        if (live_count == 0) return r;
        if (live_count == 1) begin
            n         = head_node;
            head_node = '0;
            tail_node = '0;
        end else if (from_head) begin
            n                    = head_node;
            head_node            = fwd_link[n];
            back_link[head_node] = head_node;
        end else begin
            n                   = tail_node;
            tail_node           = back_link[n];
            fwd_link[tail_node] = tail_node;
        end
        node_free[n] = 1'b1;
        live_count   = live_count - 1'b1;
        r.value  = node_value[n];
        r.handle = n;
        r.status = STAT_OK;
        r.count  = live_count;
        return r;
    endfunction

    // Inserts into the lowest-numbered free node.
    function automatic deque_result_t put_node(input bit at_head, input logic [VW-1:0] v);
        deque_result_t r;
        logic [HW-1:0] n;
        int            i;
        r.value  = '0;
        r.handle = '0;
        r.status = STAT_FULL;
        r.count  = live_count;
        if (live_count >= NODES) return r;
        n = '0;
        for (i = NODES - 1; i >= 0; i--) begin
            if (node_free[i]) n = HW'(i);
        end
        node_free[n]  = 1'b0;
        node_value[n] = v;
        if (live_count == 0) begin
            fwd_link[n]  = n;
            back_link[n] = n;
            head_node    = n;
            tail_node    = n;
        end else if (at_head) begin
            fwd_link[n]          = head_node;
            back_link[n]         = n;
            back_link[head_node] = n;
            head_node            = n;
        end else begin
            back_link[n]        = tail_node;
            fwd_link[n]         = n;
            fwd_link[tail_node] = n;
            tail_node           = n;
        end
        live_count = live_count + 1'b1;
        r.handle = n;
        r.status = STAT_OK;
        r.count  = live_count;
        return r;
    endfunction

    // Unlinks an arbitrary node. An end node is handed over to take_end so
    // that the end pointers are kept right.
    function automatic deque_result_t drop_node(input logic [HW-1:0] h);
        deque_result_t r;
        logic [HW-1:0] p;
        logic [HW-1:0] x;
        r.value  = '0;
        r.handle = '0;
        r.status = STAT_BAD;
        r.count  = live_count;
        if (live_count == 0 || node_free[h]) return r;
        if (h == head_node) return take_end(1'b1);
        if (h == tail_node) return take_end(1'b0);
        p            = back_link[h];
        x            = fwd_link[h];
        fwd_link[p]  = x;
        back_link[x] = p;
        node_free[h] = 1'b1;
        live_count   = live_count - 1'b1;
        r.value  = node_value[h];
        r.handle = h;
        r.status = STAT_OK;
        r.count  = live_count;
        return r;
    endfunction

    function automatic deque_result_t apply_deque_op(input deque_cmd_t op);
        deque_result_t r;
        case (op.fn)
            FN_INS_HEAD: r = put_node(1'b1, op.value);
            FN_INS_TAIL: r = put_node(1'b0, op.value);
            FN_RM_HEAD:  r = take_end(1'b1);
            FN_RM_TAIL:  r = take_end(1'b0);
            FN_UNLINK:   r = drop_node(op.handle);
            default: begin
                r.value  = '0;
                r.handle = '0;
                r.status = STAT_BAD;
                r.count  = live_count;
            end
        endcase
        return r;
    endfunction

    function automatic logic [HW-1:0] pick_live_node(input logic [HW-1:0] fallback);
        logic [HW-1:0] in_use [$];
        int            i;
        for (i = 0; i < NODES; i++) begin
            if (!node_free[i]) in_use.push_back(HW'(i));
        end
        if (in_use.size() == 0) return fallback;
        return in_use[$urandom_range(in_use.size() - 1, 0)];
    endfunction

    task automatic add_op(input logic [2:0] fn, input logic [VW-1:0] v,
                          input logic [HW-1:0] h, input bit live, input int unsigned gap);
        deque_cmd_t c;
        c.fn        = fn;
        c.value     = v;
        c.handle    = h;
        c.pick_live = live;
        c.gap       = gap;
        pending_ops.push_back(c);
    endtask

    task automatic check_field(input string name, input logic [VW-1:0] exp_v,
                               input logic [VW-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver. The shadow deque is advanced at the edge where a beat is
    // accepted, and the next beat is picked up in the same edge, so a live
    // handle is always chosen against the state after every earlier beat.
    // s_tvalid gets at most one assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(apply_deque_op(issued_op));
                ops_accepted++;
                send_wait = (pending_ops.size() != 0) ? pending_ops[0].gap : 0;
            end
            if (s_tvalid && !s_tready) begin
                // Hold the beat until the block takes it.
            end else if (send_wait > 0) begin
                send_wait--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                issued_op = pending_ops.pop_front();
                if (issued_op.pick_live) issued_op.handle = pick_live_node(issued_op.handle);
                s_tdata  <= {{(S_DW - VW - HW){1'b0}}, issued_op.handle, issued_op.value};
                s_tuser  <= issued_op.fn;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each result beat is checked against the oldest prediction.
    // Once, the receiver holds off for a long stretch while the sender keeps
    // offering beats, which backs the block up until s_tready drops.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $error("result beat with no operation outstanding: tdata %0h tuser %0h",
                           m_tdata, m_tuser);
                    error_count++;
                end else begin
                    deque_result_t want;
                    want = awaited_results.pop_front();
                    check_field("out_value", want.value, m_tdata[VW-1:0]);
                    check_field("out_handle", VW'(want.handle), VW'(m_tdata[VW +: HW]));
                    check_field("count", VW'(want.count), VW'(m_tdata[VW + HW +: CW]));
                    check_field("status", VW'(want.status), VW'(m_tuser));
                    check_field("tdata pad", '0, VW'(m_tdata[M_DW-1:VW + HW + CW]));
                end
                // Stretches with no receiver stalls alternate with random ones.
                if (results_seen == PRESSURE_AT)
                    recv_hold = PRESSURE_HOLD;
                else if ((results_seen / 50) % 3 == 1)
                    recv_hold = 0;
                else
                    recv_hold = $urandom_range(MAX_GAP, 0);
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // The watchdog only counts cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int          k;
        int          ins_pct;
        int          roll;
        int unsigned gap;
        logic [2:0]  fn;
        logic [VW-1:0] v;
        bit          live;
        int          bias [8];

        // Directed opening: the empty deque, undefined codes, a short list
        // built from both ends, unlinks of a middle node, the head, the tail
        // and free nodes, and removals that leave the deque empty again.
        add_op(FN_RM_HEAD,  '0, '0, 1'b0, 0);
        add_op(FN_RM_TAIL,  '1, '1, 1'b0, 3);
        add_op(FN_UNLINK,   '0, '0, 1'b0, 0);
        add_op(FN_UNLINK,   '0, '1, 1'b0, 10);
        add_op(FN_UNUSED_LO, 32'h1234_5678, 6'd5, 1'b0, 0);
        add_op(FN_UNUSED_MID, 32'h0000_0001, 6'd6, 1'b0, 1);
        add_op(FN_UNUSED_HI, '1, 6'd7, 1'b0, 0);
        add_op(FN_INS_HEAD, '0, '1, 1'b0, 0);            // node 0
        add_op(FN_INS_TAIL, '1, '0, 1'b0, 2);            // node 1
        add_op(FN_INS_HEAD, 32'h1234_5678, '0, 1'b0, 0); // node 2
        add_op(FN_INS_TAIL, 32'hA5A5_A5A5, '0, 1'b0, 0); // node 3
        add_op(FN_INS_TAIL, 32'h5A5A_5A5A, '0, 1'b0, 7); // node 4: 2 0 1 3 4
        add_op(FN_UNLINK,   '0, 6'd1, 1'b0, 0);          // middle node
        add_op(FN_UNLINK,   '0, 6'd2, 1'b0, 0);          // head node
        add_op(FN_UNLINK,   '0, 6'd4, 1'b0, 4);          // tail node
        add_op(FN_UNLINK,   '0, 6'd63, 1'b0, 0);         // never used
        add_op(FN_UNLINK,   '0, 6'd1, 1'b0, 0);          // already freed
        add_op(FN_RM_TAIL,  '0, '0, 1'b0, 0);
        add_op(FN_RM_HEAD,  '0, '0, 1'b0, 9);            // back to empty
        add_op(FN_INS_TAIL, 32'h8000_0001, '0, 1'b0, 0);
        add_op(FN_UNLINK,   '0, 6'd0, 1'b0, 0);          // sole node
        add_op(FN_INS_HEAD, 32'hDEAD_BEEF, '0, 1'b0, 0);
        add_op(FN_RM_TAIL,  '0, '0, 1'b0, 0);

        // Random part in phases of differing insert bias, so the deque fills
        // to the top, drains to empty and wanders in between several times.
        bias = '{88, 12, 55, 92, 8, 50, 80, 20};
        for (k = 0; k < RANDOM_OPS; k++) begin
            ins_pct = bias[(k / PHASE_LEN) % 8];
            roll    = $urandom_range(99, 0);
            live    = 1'b0;
            if (roll < ins_pct) begin
                fn = $urandom_range(1, 0) ? FN_INS_TAIL : FN_INS_HEAD;
            end else begin
                roll = $urandom_range(99, 0);
                if (roll < 3)
                    fn = 3'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
                else if (roll < 33)
                    fn = FN_RM_HEAD;
                else if (roll < 63)
                    fn = FN_RM_TAIL;
                else begin
                    fn   = FN_UNLINK;
                    live = ($urandom_range(9, 0) != 0);
                end
            end
            case ($urandom_range(15, 0))
                0:       v = '0;
                1:       v = '1;
                default: v = $urandom();
            endcase
            // Every few dozen beats the sender runs back to back.
            gap = ((k / 37) % 4 == 0) ? 0 : $urandom_range(MAX_GAP, 0);
            add_op(fn, v, HW'($urandom_range(NODES - 1, 0)), live, gap);
        end
        ops_total = pending_ops.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (ops_accepted != ops_total || awaited_results.size() != 0)
            @(posedge aclk);
        // Keep the clock running for DRAIN_CYCLES so that a stray extra result would still be caught.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
